### hw/rtl/assert_macros.svh
// Assertion macros for the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define PBAM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition is followed by another one in the next cycle.
`define PBAM_ASSERT_NEXT(name, cond, follow, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (follow)) \
        else $error(msg);

`endif

### hw/rtl/pbam_pkg.sv
// Shared types and constants of the paged bank address map.
`default_nettype none

package pbam_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int ADDR_BITS_DEF     = 16;
    localparam int INDEX_BITS_DEF    = 20;
    localparam int BUFFER_COUNT_DEF  = 16;

    localparam logic [3:0] SHIFT_MIN   = 4'd10;
    localparam logic [3:0] SHIFT_MAX   = 4'd13;
    localparam logic [3:0] SHIFT_RESET = 4'd13;

    // Range cursor: an exclusive end below 2^17 plus one page of overshoot.
    localparam int CURSOR_W = 18;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_MAP   = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DIV,
        ST_FILL,
        ST_ADV
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/paged_bank_address_map.sv
// Top level of the paged bank address map: page table memory, sequencer and result port.
//
// Usage: drive an item on the input ports with start high while busy is low; the
// item is taken at that edge. Mode read or write looks up the page of address and
// translates it to a buffer id and a byte index; mode map fills every page of
// [address, range_limit) with one buffer (empty if none or size 0); mode clear
// marks those pages empty. Each item gives one result, shown for one cycle with
// result_valid high; the receiver cannot hold it off. page_shift is written
// through cfg_we/cfg_wdata while busy is low and no result is pending.
// Structure: the page table is one memory with a registered read. A hit runs the
// shared modulo unit, one bit per cycle over INDEX_BITS+1 bits, before the result
// is loaded; a miss loads its result straight from the lookup. A map item with a
// buffer runs the modulo unit once per page, a clear item writes its pages without
// it. One item is worked on at a time.
// Reset: every page reads empty and read-only (per-entry valid bits are cleared
// at once) and page_shift returns to 13; the block is ready right after reset.
`default_nettype none
`include "assert_macros.svh"

module paged_bank_address_map #(
    parameter int TABLE_ENTRIES = pbam_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_BITS     = pbam_pkg::ADDR_BITS_DEF,
    parameter int INDEX_BITS    = pbam_pkg::INDEX_BITS_DEF,
    parameter int BUFFER_COUNT  = pbam_pkg::BUFFER_COUNT_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic [15:0] address,
    input  wire logic [16:0] range_limit,
    input  wire logic [7:0]  bus_value,
    input  wire logic [3:0]  buffer_id,
    input  wire logic [20:0] buffer_size,
    input  wire logic [19:0] start_offset,
    input  wire logic        map_read_only,
    input  wire logic        map_is_sram,
    input  wire logic        has_buffer,
    output logic             result_valid,
    output logic             hit,
    output logic [3:0]       target_buffer,
    output logic [19:0]      buffer_index,
    output logic [7:0]       data_value,
    output logic             sram_dirty
);

    localparam int PW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int IW  = INDEX_BITS;
    localparam int SZW = INDEX_BITS + 1;
    localparam int CRW = pbam_pkg::CURSOR_W;
    localparam logic [31:0] MAX_SIZE = 32'd1 << INDEX_BITS;

    typedef struct packed {
        logic [3:0]     buffer;
        logic [SZW-1:0] size;
        logic [IW-1:0]  offset;
        logic           empty;
        logic           ro;
        logic           sram;
    } entry_t;

    pbam_pkg::state_t state_reg, state_next;

    logic [3:0]           page_shift_reg;
    pbam_pkg::mode_t      mode_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [16:0]          end_reg;
    logic [7:0]           bus_reg;
    logic [3:0]           id_reg;
    logic [SZW-1:0]       sz_reg;
    logic [IW-1:0]        off_reg;
    logic                 ro_reg;
    logic                 sram_reg;
    logic                 clr_reg;
    logic [CRW-1:0]       cursor_reg;
    logic                 in_table_reg;

    entry_t mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    entry_t               rd_entry_reg;
    logic                 rd_valid_reg;

    logic                 result_valid_reg;
    logic                 hit_reg;
    logic [3:0]           target_reg;
    logic [19:0]          index_reg;
    logic [7:0]           data_reg;
    logic                 dirty_reg;

    // Control from the sequencer.
    logic           accept;
    logic           mem_re;
    logic           mem_we;
    logic           div_go;
    logic           res_load;
    logic           res_hit;
    logic           advance;
    logic           take_rem;
    logic [SZW-1:0] div_dividend;
    logic [SZW-1:0] div_divisor;
    logic           div_done;
    logic [SZW-1:0] div_rem;

    logic [3:0]     sh;
    logic [CRW-1:0] psize;
    logic [CRW-1:0] acc_page;
    logic [CRW-1:0] cur_page;
    logic           fill_active;
    logic           lookup_hit;
    logic [SZW-1:0] sz_in;
    logic [3:0]     id_in;
    logic [CRW-1:0] addr_low;
    logic [31:0]    rem_ext;
    entry_t         wr_entry;

    always_comb
    begin
        if (page_shift_reg < pbam_pkg::SHIFT_MIN)
        begin
            sh = pbam_pkg::SHIFT_MIN;
        end
        else if (page_shift_reg > pbam_pkg::SHIFT_MAX)
        begin
            sh = pbam_pkg::SHIFT_MAX;
        end
        else
        begin
            sh = page_shift_reg;
        end
    end

    assign psize    = CRW'(1) << sh;
    assign acc_page = CRW'(address[ADDR_BITS-1:0]) >> sh;
    assign cur_page = cursor_reg >> sh;
    assign addr_low = CRW'(addr_reg) & (psize - CRW'(1));
    assign fill_active = (cursor_reg < CRW'(end_reg)) && (cur_page < CRW'(TABLE_ENTRIES));
    assign lookup_hit  = in_table_reg && rd_valid_reg && !rd_entry_reg.empty
                         && ((mode_reg == pbam_pkg::MODE_READ) || !rd_entry_reg.ro);
    assign rem_ext = 32'(div_rem);

    // Oversized buffers saturate to the largest index space.
    always_comb
    begin
        if (32'(buffer_size) > MAX_SIZE)
        begin
            sz_in = SZW'(MAX_SIZE);
        end
        else
        begin
            sz_in = SZW'(buffer_size);
        end
    end

    always_comb
    begin
        id_in = buffer_id;
        for (int i = 0; i < 8; i++)
        begin
            if (32'(id_in) >= 32'(BUFFER_COUNT))
            begin
                id_in = 4'(32'(id_in) - 32'(BUFFER_COUNT));
            end
        end
    end

    always_comb
    begin
        wr_entry.buffer = clr_reg ? 4'd0 : id_reg;
        wr_entry.size   = sz_reg;
        wr_entry.offset = clr_reg ? '0 : off_reg;
        wr_entry.empty  = clr_reg;
        wr_entry.ro     = clr_reg ? 1'b1 : ro_reg;
        wr_entry.sram   = clr_reg ? 1'b0 : sram_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        accept       = 1'b0;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        div_go       = 1'b0;
        res_load     = 1'b0;
        res_hit      = 1'b0;
        advance      = 1'b0;
        take_rem     = 1'b0;
        div_dividend = SZW'(off_reg) + SZW'(psize);
        div_divisor  = sz_reg;
        case (state_reg)
            pbam_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    accept = 1'b1;
                    if (mode[1])
                    begin
                        state_next = pbam_pkg::ST_FILL;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        state_next = pbam_pkg::ST_LOOKUP;
                    end
                end
            end
            pbam_pkg::ST_LOOKUP:
            begin
                div_dividend = SZW'(addr_low) + SZW'(rd_entry_reg.offset);
                div_divisor  = (rd_entry_reg.size == '0) ? SZW'(1) : rd_entry_reg.size;
                if (lookup_hit)
                begin
                    div_go     = 1'b1;
                    state_next = pbam_pkg::ST_DIV;
                end
                else
                begin
                    res_load   = 1'b1;
                    state_next = pbam_pkg::ST_IDLE;
                end
            end
            pbam_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    res_load   = 1'b1;
                    res_hit    = 1'b1;
                    state_next = pbam_pkg::ST_IDLE;
                end
            end
            pbam_pkg::ST_FILL:
            begin
                if (fill_active)
                begin
                    mem_we = 1'b1;
                    if (clr_reg)
                    begin
                        advance = 1'b1;
                    end
                    else
                    begin
                        div_go     = 1'b1;
                        state_next = pbam_pkg::ST_ADV;
                    end
                end
                else
                begin
                    res_load   = 1'b1;
                    res_hit    = 1'b1;
                    state_next = pbam_pkg::ST_IDLE;
                end
            end
            pbam_pkg::ST_ADV:
            begin
                if (div_done)
                begin
                    take_rem   = 1'b1;
                    advance    = 1'b1;
                    state_next = pbam_pkg::ST_FILL;
                end
            end
            default:
            begin
                state_next = pbam_pkg::ST_IDLE;
            end
        endcase
    end

    pbam_mod #(
        .W (SZW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pbam_pkg::ST_IDLE;
            page_shift_reg   <= pbam_pkg::SHIFT_RESET;
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= res_load;
            if (cfg_we)
            begin
                page_shift_reg <= cfg_wdata;
            end
            if (mem_we)
            begin
                valid_reg[cur_page[PW-1:0]] <= 1'b1;
            end
        end
    end

    // Page table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cur_page[PW-1:0]] <= wr_entry;
        end
        if (mem_re)
        begin
            rd_entry_reg <= mem[acc_page[PW-1:0]];
            rd_valid_reg <= valid_reg[acc_page[PW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= pbam_pkg::mode_t'(mode);
            addr_reg     <= address[ADDR_BITS-1:0];
            end_reg      <= range_limit;
            bus_reg      <= bus_value;
            id_reg       <= id_in;
            sz_reg       <= sz_in;
            off_reg      <= IW'(32'(start_offset));
            ro_reg       <= map_read_only;
            sram_reg     <= map_is_sram;
            clr_reg      <= (mode == pbam_pkg::MODE_CLEAR) || !has_buffer || (sz_in == '0);
            cursor_reg   <= CRW'(address[ADDR_BITS-1:0]);
            in_table_reg <= acc_page < CRW'(TABLE_ENTRIES);
        end
        else
        begin
            if (take_rem)
            begin
                off_reg <= div_rem[IW-1:0];
            end
            if (advance)
            begin
                cursor_reg <= cursor_reg + psize;
            end
        end
        if (res_load)
        begin
            hit_reg  <= res_hit;
            data_reg <= mode_reg[1] ? 8'd0 : bus_reg;
            if (res_hit && !mode_reg[1])
            begin
                target_reg <= rd_entry_reg.buffer;
                index_reg  <= rem_ext[19:0];
                dirty_reg  <= (mode_reg == pbam_pkg::MODE_WRITE) && rd_entry_reg.sram;
            end
            else
            begin
                target_reg <= 4'd0;
                index_reg  <= 20'd0;
                dirty_reg  <= 1'b0;
            end
        end
    end

    assign busy          = (state_reg != pbam_pkg::ST_IDLE);
    assign result_valid  = result_valid_reg;
    assign hit           = hit_reg;
    assign target_buffer = target_reg;
    assign buffer_index  = index_reg;
    assign data_value    = data_reg;
    assign sram_dirty    = dirty_reg;

    `PBAM_ASSERT_NEXT(a_single_result, result_valid, !result_valid, "result strobe held twice")
    `PBAM_ASSERT(a_result_when_free, result_valid |-> !busy, "result shown while busy")
    `PBAM_ASSERT(a_div_owner, div_done |-> (state_reg == pbam_pkg::ST_DIV
        || state_reg == pbam_pkg::ST_ADV), "modulo finished with no user")
    `PBAM_ASSERT(a_no_rw_overlap, !(mem_we && mem_re), "table read and write together")

endmodule

`default_nettype wire

### hw/rtl/pbam_mod.sv
// Iterative restoring modulo unit, one dividend bit per cycle.
`default_nettype none

module pbam_mod #(
    parameter int W = pbam_pkg::INDEX_BITS_DEF + 1
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         go,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  dvd_reg;
    logic [W-1:0]  dvs_reg;
    logic [W-1:0]  rem_reg;
    logic [CW-1:0] count_reg;
    logic          run_reg;
    logic          done_reg;
    logic [W:0]    trial;
    logic [W-1:0]  rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg   <= 1'b1;
                count_reg <= CW'(W);
            end
            else if (run_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire
